FILE: src/wns_pkg.sv
package wns_pkg;

  localparam int ROW_BITS  = 10;
  localparam int COL_BITS  = 8;
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;

  // Bit of paddr that selects the register (registers sit 4 bytes apart).
  localparam int REG_SEL_BIT = 2;

  localparam logic [ROW_BITS-1:0] LAST_ROW_RESET = ROW_BITS'(1);
  localparam logic [COL_BITS-1:0] LAST_COL_RESET = COL_BITS'(1);

  // Result queue between the arithmetic pipeline and the output channel.
  localparam int OUT_DEPTH    = 8;
  localparam int OUT_PTR_BITS = 3;

  typedef enum logic {
    REG_LAST_ROW,
    REG_LAST_COL
  } reg_e;

  // Odd factor of the divisor once its power of two has been shifted out.
  typedef enum logic [1:0] {
    DIV_1,
    DIV_3,
    DIV_5,
    DIV_7
  } div_e;

  // Weight sum in half units, right shift and odd factor of the divisor 2*W.
  typedef struct packed {
    logic [3:0] wt;
    logic [1:0] sh;
    div_e       dv;
  } div_sel_t;

  // Per-item control that travels beside the data through the pipeline.
  typedef struct packed {
    logic                vld;    // item changes the window
    logic                a_vld;  // result for the column left of the new cell
    logic                b_vld;  // result for the column of the new cell (row end)
    logic                up;     // row above is inside the grid
    logic                dn;     // row below is inside the grid
    logic                lf_a;   // left neighbour present for result a
    logic                lf_b;   // left neighbour present for result b
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;    // column of result b; result a is one left
    logic                fe;     // result b closes the frame
  } ctl_t;

  // a: rows present besides the centre row, b: columns besides the centre.
  // W = 2 + 2a + 2b + ab, divisor 2W = 4, 8, 12, 14, 20 or 28.
  function automatic div_sel_t div_select(input logic [1:0] a, input logic [1:0] b);
    div_sel_t sel;
    sel = '{wt: 4'd2, sh: 2'd2, dv: DIV_1};
    case ({a, b})
      4'b0000: sel = '{wt: 4'd2,  sh: 2'd2, dv: DIV_1};
      4'b0001,
      4'b0100: sel = '{wt: 4'd4,  sh: 2'd3, dv: DIV_1};
      4'b0010,
      4'b1000: sel = '{wt: 4'd6,  sh: 2'd2, dv: DIV_3};
      4'b0101: sel = '{wt: 4'd7,  sh: 2'd1, dv: DIV_7};
      4'b0110,
      4'b1001: sel = '{wt: 4'd10, sh: 2'd2, dv: DIV_5};
      4'b1010: sel = '{wt: 4'd14, sh: 2'd2, dv: DIV_7};
      default: sel = '{wt: 4'd2,  sh: 2'd2, dv: DIV_1};
    endcase
    return sel;
  endfunction

endpackage

FILE: src/wns_if.sv
interface wns_in_if #(
  parameter int LEVEL_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] level;
  logic                  flush;

  modport source (output valid, level, flush, input ready);
  modport sink   (input valid, level, flush, output ready);
endinterface

interface wns_out_if #(
  parameter int LEVEL_BITS = 16
) ();
  logic                           valid;
  logic                           ready;
  logic [LEVEL_BITS-1:0]          average;
  logic [wns_pkg::ROW_BITS-1:0]   row;
  logic [wns_pkg::COL_BITS-1:0]   col;
  logic                           frame_end;

  modport source (output valid, average, row, col, frame_end, input ready);
  modport sink   (input valid, average, row, col, frame_end, output ready);
endinterface

FILE: src/wns_cfg.sv
module wns_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wns_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [wns_pkg::DATA_BITS-1:0]   pwdata,
  output logic [wns_pkg::DATA_BITS-1:0]   prdata,
  output logic                            pready,
  output logic [wns_pkg::ROW_BITS-1:0]    last_row_o,
  output logic [wns_pkg::COL_BITS-1:0]    last_col_o
);

  logic                         wr_en;
  wns_pkg::reg_e                sel;
  logic [wns_pkg::ROW_BITS-1:0] last_row_q;
  logic [wns_pkg::COL_BITS-1:0] last_col_q;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign sel    = wns_pkg::reg_e'(paddr[wns_pkg::REG_SEL_BIT]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_row_q <= wns_pkg::LAST_ROW_RESET;
      last_col_q <= wns_pkg::LAST_COL_RESET;
    end else if (wr_en) begin
      case (sel)
        wns_pkg::REG_LAST_ROW: last_row_q <= pwdata[wns_pkg::ROW_BITS-1:0];
        wns_pkg::REG_LAST_COL: last_col_q <= pwdata[wns_pkg::COL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      wns_pkg::REG_LAST_ROW: prdata = wns_pkg::DATA_BITS'(last_row_q);
      wns_pkg::REG_LAST_COL: prdata = wns_pkg::DATA_BITS'(last_col_q);
      default:               prdata = '0;
    endcase
  end

  assign last_row_o = last_row_q;
  assign last_col_o = last_col_q;

endmodule

FILE: src/wns_line_buf.sv
module wns_line_buf #(
  parameter int LINE_DEPTH = 256,
  parameter int LEVEL_BITS = 16,
  localparam int AW = $clog2(LINE_DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [AW-1:0]         idx_i,
  input  logic [LEVEL_BITS-1:0] level_i,
  input  logic                  drain_i,
  output logic [LEVEL_BITS-1:0] top_o,
  output logic [LEVEL_BITS-1:0] mid_o,
  output logic [LEVEL_BITS-1:0] bot_o
);

  logic [LEVEL_BITS-1:0] older_mem [LINE_DEPTH];
  logic [LEVEL_BITS-1:0] prior_mem [LINE_DEPTH];

  logic                  vld_q;
  logic                  fwd_q;
  logic [AW-1:0]         idx_q;
  logic [LEVEL_BITS-1:0] lvl_q;
  logic                  drn_q;
  logic [LEVEL_BITS-1:0] rd_older_q;
  logic [LEVEL_BITS-1:0] rd_prior_q;
  logic [LEVEL_BITS-1:0] fwd_older_q;
  logic [LEVEL_BITS-1:0] fwd_prior_q;

  logic                  wr_en;
  logic                  hit;
  logic [LEVEL_BITS-1:0] eff_older;
  logic [LEVEL_BITS-1:0] eff_prior;

  // The write of the item in flight lands in the cycle after its read; a read of the
  // same column in that cycle takes the new values from the bypass.
  assign wr_en     = vld_q & ~drn_q;
  assign hit       = en_i & wr_en & (idx_i == idx_q);
  assign eff_older = fwd_q ? fwd_older_q : rd_older_q;
  assign eff_prior = fwd_q ? fwd_prior_q : rd_prior_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      older_mem[idx_q] <= eff_prior;
      prior_mem[idx_q] <= lvl_q;
    end
    if (en_i) begin
      rd_older_q <= older_mem[idx_i];
      rd_prior_q <= prior_mem[idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idx_q       <= idx_i;
      lvl_q       <= level_i;
      drn_q       <= drain_i;
      fwd_older_q <= eff_prior;
      fwd_prior_q <= lvl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      fwd_q <= 1'b0;
    end else begin
      vld_q <= en_i;
      fwd_q <= hit;
    end
  end

  assign top_o = eff_older;
  assign mid_o = eff_prior;
  assign bot_o = drn_q ? '0 : lvl_q;

endmodule

FILE: src/wns_smooth.sv
module wns_smooth #(
  parameter int LEVEL_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wns_pkg::ctl_t         ctl_i,
  input  logic [LEVEL_BITS-1:0] top_i,
  input  logic [LEVEL_BITS-1:0] mid_i,
  input  logic [LEVEL_BITS-1:0] bot_i,
  output logic [1:0]            push_o,
  output logic [LEVEL_BITS-1:0] avg_a_o,
  output logic [LEVEL_BITS-1:0] avg_b_o,
  output wns_pkg::ctl_t         ctl_o,
  output logic [2:0]            inflight_o
);

  localparam int SW = LEVEL_BITS + 4;  // weighted sum in half units
  localparam int NW = LEVEL_BITS + 5;  // 2S + W
  localparam int XW = LEVEL_BITS + 4;  // numerator after the power-of-two shift
  localparam int K  = XW + 3;          // reciprocal precision, exact for x < 2^XW
  localparam int MW = K + 1;
  localparam int PW = XW + MW;

  localparam logic [MW-1:0] RECIP_1 = MW'(64'd1 << K);
  localparam logic [MW-1:0] RECIP_3 = MW'((64'd1 << K) / 3 + 64'd1);
  localparam logic [MW-1:0] RECIP_5 = MW'((64'd1 << K) / 5 + 64'd1);
  localparam logic [MW-1:0] RECIP_7 = MW'((64'd1 << K) / 7 + 64'd1);

  logic [8:0][LEVEL_BITS-1:0] win_q;
  logic [8:0][LEVEL_BITS-1:0] win_d;

  logic [SW-1:0]        sum_a;
  logic [SW-1:0]        sum_b;
  wns_pkg::div_sel_t    sel_a;
  wns_pkg::div_sel_t    sel_b;
  logic [NW-1:0]        num_a;
  logic [NW-1:0]        num_b;

  logic [XW-1:0]        x_a_q;
  logic [XW-1:0]        x_b_q;
  wns_pkg::div_e        dv_a_q;
  wns_pkg::div_e        dv_b_q;
  wns_pkg::ctl_t        ctl1_q;

  logic [PW-1:0]        p_a_q;
  logic [PW-1:0]        p_b_q;
  wns_pkg::ctl_t        ctl2_q;

  // Weighted sum around window column mid; row and column masks drop
  // neighbours outside the grid. Diagonals weigh 1, the rest 2.
  function automatic logic [SW-1:0] lane_sum(
    input logic [8:0][LEVEL_BITS-1:0] w,
    input int                         mid,
    input logic                       up,
    input logic                       dn,
    input logic                       lf,
    input logic                       rt
  );
    logic [SW-1:0] s;
    logic          rp;
    logic          cp;
    int            k;
    s = '0;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dk = 0; dk < 3; dk++) begin
        rp = (dr == 0) ? up : ((dr == 2) ? dn : 1'b1);
        cp = (dk == 0) ? lf : ((dk == 2) ? rt : 1'b1);
        k  = mid - 1 + dk;
        if (rp && cp && (k < 3)) begin
          if ((dr != 1) && (dk != 1)) begin
            s = s + SW'(w[dr * 3 + k]);
          end else begin
            s = s + SW'({w[dr * 3 + k], 1'b0});
          end
        end
      end
    end
    return s;
  endfunction

  function automatic logic [MW-1:0] recip(input wns_pkg::div_e dv);
    logic [MW-1:0] m;
    case (dv)
      wns_pkg::DIV_1: m = RECIP_1;
      wns_pkg::DIV_3: m = RECIP_3;
      wns_pkg::DIV_5: m = RECIP_5;
      wns_pkg::DIV_7: m = RECIP_7;
      default:        m = RECIP_1;
    endcase
    return m;
  endfunction

  // Shift the window left by one column and bring in the new column.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r * 3]     = win_q[r * 3 + 1];
      win_d[r * 3 + 1] = win_q[r * 3 + 2];
    end
    win_d[2] = top_i;
    win_d[5] = mid_i;
    win_d[8] = bot_i;
  end

  always_comb begin
    sum_a = lane_sum(win_d, 1, ctl_i.up, ctl_i.dn, ctl_i.lf_a, 1'b1);
    sum_b = lane_sum(win_d, 2, ctl_i.up, ctl_i.dn, ctl_i.lf_b, 1'b0);
    sel_a = wns_pkg::div_select(2'({1'b0, ctl_i.up}) + 2'({1'b0, ctl_i.dn}),
                                2'({1'b0, ctl_i.lf_a}) + 2'd1);
    sel_b = wns_pkg::div_select(2'({1'b0, ctl_i.up}) + 2'({1'b0, ctl_i.dn}),
                                2'({1'b0, ctl_i.lf_b}));
    num_a = {sum_a, 1'b0} + NW'(sel_a.wt);
    num_b = {sum_b, 1'b0} + NW'(sel_b.wt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (ctl_i.vld) begin
      win_q <= win_d;
    end
  end

  // Stage 1: numerators with the power of two of the divisor shifted out.
  always_ff @(posedge clk_i) begin
    x_a_q  <= XW'(num_a >> sel_a.sh);
    x_b_q  <= XW'(num_b >> sel_b.sh);
    dv_a_q <= sel_a.dv;
    dv_b_q <= sel_b.dv;
  end

  // Stage 2: multiply by the reciprocal of the odd factor.
  always_ff @(posedge clk_i) begin
    p_a_q <= PW'(x_a_q) * PW'(recip(dv_a_q));
    p_b_q <= PW'(x_b_q) * PW'(recip(dv_b_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
    end
  end

  assign avg_a_o    = p_a_q[K +: LEVEL_BITS];
  assign avg_b_o    = p_b_q[K +: LEVEL_BITS];
  assign push_o     = {ctl2_q.b_vld, ctl2_q.a_vld};
  assign ctl_o      = ctl2_q;
  assign inflight_o = 3'({1'b0, ctl1_q.a_vld}) + 3'({1'b0, ctl1_q.b_vld})
                    + 3'({1'b0, ctl2_q.a_vld}) + 3'({1'b0, ctl2_q.b_vld});

endmodule

FILE: src/wns_out_fifo.sv
module wns_out_fifo #(
  parameter int DW = 35
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [1:0]                      push_i,
  input  logic [DW-1:0]                   data_a_i,
  input  logic [DW-1:0]                   data_b_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic [DW-1:0]                   data_o,
  output logic [wns_pkg::OUT_PTR_BITS:0]  count_o
);

  localparam int PB = wns_pkg::OUT_PTR_BITS;

  logic [DW-1:0] buf_q [wns_pkg::OUT_DEPTH];
  logic [PB-1:0] wr_ptr_q;
  logic [PB-1:0] rd_ptr_q;
  logic [PB:0]   cnt_q;
  logic [PB-1:0] b_ptr;
  logic [PB:0]   n_push;
  logic          pop;

  assign pop    = valid_o & ready_i;
  assign n_push = (PB + 1)'(push_i[0]) + (PB + 1)'(push_i[1]);
  // b follows a in the same cycle when both are pushed.
  assign b_ptr  = wr_ptr_q + PB'(push_i[0]);

  always_ff @(posedge clk_i) begin
    if (push_i[0]) begin
      buf_q[wr_ptr_q] <= data_a_i;
    end
    if (push_i[1]) begin
      buf_q[b_ptr] <= data_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PB'(n_push);
      rd_ptr_q <= rd_ptr_q + PB'(pop);
      cnt_q    <= cnt_q + n_push - (PB + 1)'(pop);
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rd_ptr_q];
  assign count_o = cnt_q;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PB + 1)'(wns_pkg::OUT_DEPTH))
    else $error("result queue overflow");
`endif

endmodule

FILE: src/weighted_neighbour_smoothing.sv
// Weighted 3x3 smoothing of a raster stream of grid levels.
//
// item_i takes one level per beat in raster order, rows 0..last_row and
// columns 0..last_col. After the last cell of a frame send last_col+1 beats
// with flush set; they drain the last row. A flush beat outside the drain,
// or a level beat during it, is taken and dropped without effect.
// result_o gives one averaged cell per beat, in raster order, lagging the
// input by one row and one column; frame_end marks the final cell.
// Registers over APB: last_row at 0x0, last_col at 0x4 (write them idle).
//
// Throughput: one item per cycle while input ready is high. An item at
// the end of a row yields two results, so a stream of whole rows drains
// its results at the output rate. A result passes the line buffer read, the
// window/sum stage and the reciprocal multiply before the output queue.
// Input ready follows the free space of the 8-beat result queue, counting
// results still in the pipeline; when the receiver stalls the queue fills
// and ready drops, and nothing is lost.
// Reset: position counters back to row 0 column 0, both registers to 1,
// pipeline and queue empty. The line buffers are not cleared.
module weighted_neighbour_smoothing #(
  parameter int LINE_DEPTH = 256,
  parameter int LEVEL_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  wns_in_if.sink                          item_i,
  wns_out_if.source                       result_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wns_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [wns_pkg::DATA_BITS-1:0]   pwdata,
  output logic [wns_pkg::DATA_BITS-1:0]   prdata,
  output logic                            pready
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int RB = wns_pkg::ROW_BITS;
  localparam int CB = wns_pkg::COL_BITS;
  localparam int DW = LEVEL_BITS + RB + CB + 1;
  localparam int SB = wns_pkg::OUT_PTR_BITS + 2;

  logic [RB-1:0] last_row;
  logic [CB-1:0] last_col;

  logic [RB-1:0] in_row_q;
  logic [CB-1:0] in_col_q;
  logic [AW-1:0] col_idx_q;
  logic [RB-1:0] out_row_q;
  logic          draining_q;

  logic          acc;
  logic          fire;
  logic          row_end;
  logic          emit;
  logic [RB-1:0] erow;
  wns_pkg::ctl_t ctl0_d;
  wns_pkg::ctl_t ctl0_q;

  logic [LEVEL_BITS-1:0] cell_top;
  logic [LEVEL_BITS-1:0] cell_mid;
  logic [LEVEL_BITS-1:0] cell_bot;

  logic [1:0]            push;
  logic [LEVEL_BITS-1:0] avg_a;
  logic [LEVEL_BITS-1:0] avg_b;
  wns_pkg::ctl_t         ctl2;
  logic [2:0]            inflight;
  logic [DW-1:0]         word_a;
  logic [DW-1:0]         word_b;
  logic [DW-1:0]         head;
  logic [wns_pkg::OUT_PTR_BITS:0] q_cnt;
  logic [SB-1:0]         committed;

  wns_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .last_row_o (last_row),
    .last_col_o (last_col)
  );

  // Hold input while the queue cannot take two more results on top of
  // everything already committed.
  assign committed = SB'(q_cnt) + SB'(inflight)
                   + SB'(ctl0_q.a_vld) + SB'(ctl0_q.b_vld);
  assign item_i.ready = (committed <= SB'(wns_pkg::OUT_DEPTH - 2));

  assign acc     = item_i.valid & item_i.ready;
  // Only a beat that matches the drain state does anything.
  assign fire    = acc & (item_i.flush == draining_q);
  assign row_end = (in_col_q >= last_col);
  assign emit    = draining_q | (in_row_q != '0);
  assign erow    = draining_q ? out_row_q : (in_row_q - RB'(1));

  always_comb begin
    ctl0_d       = '0;
    ctl0_d.vld   = fire;
    ctl0_d.a_vld = fire & emit & (in_col_q != '0);
    ctl0_d.b_vld = fire & emit & row_end;
    ctl0_d.up    = (erow != '0);
    ctl0_d.dn    = ~draining_q;
    ctl0_d.lf_a  = (in_col_q >= CB'(2));
    ctl0_d.lf_b  = (in_col_q != '0);
    ctl0_d.row   = erow;
    ctl0_d.col   = in_col_q;
    ctl0_d.fe    = draining_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else begin
      ctl0_q <= ctl0_d;
    end
  end

  // Raster position, line buffer column and drain state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q   <= '0;
      in_col_q   <= '0;
      col_idx_q  <= '0;
      out_row_q  <= '0;
      draining_q <= 1'b0;
    end else if (fire) begin
      if (row_end && !draining_q && (in_row_q >= last_row)) begin
        // The drain averages the row that just came in.
        out_row_q <= in_row_q;
      end else if (emit) begin
        out_row_q <= erow;
      end
      if (row_end) begin
        in_col_q  <= '0;
        col_idx_q <= '0;
        if (draining_q) begin
          draining_q <= 1'b0;
          in_row_q   <= '0;
        end else if (in_row_q >= last_row) begin
          // Last row is in: drain it with flush beats.
          draining_q <= 1'b1;
          in_row_q   <= '0;
        end else begin
          in_row_q <= in_row_q + RB'(1);
        end
      end else begin
        in_col_q  <= in_col_q + CB'(1);
        col_idx_q <= (col_idx_q == AW'(LINE_DEPTH - 1)) ? '0 : col_idx_q + AW'(1);
      end
    end
  end

  wns_line_buf #(
    .LINE_DEPTH (LINE_DEPTH),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_line_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (fire),
    .idx_i   (col_idx_q),
    .level_i (item_i.level),
    .drain_i (draining_q),
    .top_o   (cell_top),
    .mid_o   (cell_mid),
    .bot_o   (cell_bot)
  );

  wns_smooth #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_smooth (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl0_q),
    .top_i      (cell_top),
    .mid_i      (cell_mid),
    .bot_i      (cell_bot),
    .push_o     (push),
    .avg_a_o    (avg_a),
    .avg_b_o    (avg_b),
    .ctl_o      (ctl2),
    .inflight_o (inflight)
  );

  // Result a is the cell left of the new column, result b the row's last cell.
  assign word_a = {avg_a, ctl2.row, ctl2.col - CB'(1), 1'b0};
  assign word_b = {avg_b, ctl2.row, ctl2.col, ctl2.fe};

  wns_out_fifo #(
    .DW (DW)
  ) u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_a_i (word_a),
    .data_b_i (word_b),
    .valid_o  (result_o.valid),
    .ready_i  (result_o.ready),
    .data_o   (head),
    .count_o  (q_cnt)
  );

  assign result_o.average   = head[DW-1 -: LEVEL_BITS];
  assign result_o.row       = head[CB + RB : CB + 1];
  assign result_o.col       = head[CB:1];
  assign result_o.frame_end = head[0];

`ifndef SYNTHESIS
  a_drain_row_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    draining_q |-> (in_row_q == '0))
    else $error("row counter not cleared while draining");

  a_col_idx_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_col_q == '0) |-> (col_idx_q == '0))
    else $error("line buffer column out of step with column counter");

  a_drain_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && draining_q && row_end) |=> (!draining_q && (in_col_q == '0)))
    else $error("drain did not end after the last flush beat");

  a_frame_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push[1] && ctl2.fe) |-> !ctl2.dn)
    else $error("frame end outside the drain");
`endif

endmodule

FILE: tb/sv/tb_weighted_neighbour_smoothing.sv
module tb_weighted_neighbour_smoothing;

  localparam int LINE_DEPTH = 256;
  localparam int LEVEL_BITS = 16;

  // One beat on the item channel.
  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic                  flush;
  } grid_beat_t;

  // One averaged cell as it should appear on the result channel.
  typedef struct packed {
    logic [LEVEL_BITS-1:0]        average;
    logic [wns_pkg::ROW_BITS-1:0] row;
    logic [wns_pkg::COL_BITS-1:0] col;
    logic                         frame_end;
  } cell_avg_t;

  logic clk = 1'b0;
  logic rst_n;

  // APB side of the register port
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [wns_pkg::ADDR_BITS-1:0] paddr;
  logic [wns_pkg::DATA_BITS-1:0] pwdata;
  logic [wns_pkg::DATA_BITS-1:0] prdata;
  logic                          pready;

  wns_in_if  #(.LEVEL_BITS(LEVEL_BITS)) item_if ();
  wns_out_if #(.LEVEL_BITS(LEVEL_BITS)) res_if ();

  weighted_neighbour_smoothing #(
    .LINE_DEPTH(LINE_DEPTH),
    .LEVEL_BITS(LEVEL_BITS)
  ) i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_if),
    .result_o(res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Stimulus and scoreboard storage
  grid_beat_t pending_beats[$];
  cell_avg_t  cells_due[$];
  int         mismatches = 0;
  int         stim_items = 0;

  // Idling control: gap_pct and calm shared by both channel sides, hold_off for results
  int   gap_pct = 0;
  bit   calm = 1'b0;
  logic hold_off;
  event squeeze_ev;

  // Shadow of the grid registers and of the smoothing state
  logic [wns_pkg::ROW_BITS-1:0] cfg_last_row;
  logic [wns_pkg::COL_BITS-1:0] cfg_last_col;
  logic [LEVEL_BITS-1:0]        older_line[LINE_DEPTH];
  logic [LEVEL_BITS-1:0]        prior_line[LINE_DEPTH];
  logic [LEVEL_BITS-1:0]        win[9];
  logic [wns_pkg::ROW_BITS-1:0] in_row;
  logic [wns_pkg::COL_BITS-1:0] in_col;
  logic [wns_pkg::ROW_BITS-1:0] out_row;
  bit                           draining;

  // Clock: 4 time units per period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Weighted mean around window column cc of the middle row. Work in half
  // units: edge neighbours and the centre weigh 2, diagonals weigh 1, and
  // round to nearest with ties upward.
  function automatic logic [LEVEL_BITS-1:0] weighted_mean(input int cc, input bit up,
                                                          input bit dn, input bit lf,
                                                          input bit rt);
    int unsigned sum;
    int unsigned wsum;
    int unsigned wt;
    int          k;
    sum  = 0;
    wsum = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dk = -1; dk <= 1; dk++) begin
        k = cc + dk;
        // Drop neighbours outside the grid or outside the window.
        if ((dr < 0 && !up) || (dr > 0 && !dn) || (dk < 0 && !lf) || (dk > 0 && !rt))
          continue;
        if (k < 0 || k > 2)
          continue;
        wt   = (dr != 0 && dk != 0) ? 1 : 2;
        sum  += wt * win[(1 + dr) * 3 + k];
        wsum += wt;
      end
    end
    return LEVEL_BITS'((2 * sum + wsum) / (2 * wsum));
  endfunction

  function automatic cell_avg_t cell_avg(input logic [LEVEL_BITS-1:0] average,
                                         input logic [wns_pkg::ROW_BITS-1:0] row,
                                         input logic [wns_pkg::COL_BITS-1:0] col,
                                         input logic frame_end);
    cell_avg_t cv;
    cv.average   = average;
    cv.row       = row;
    cv.col       = col;
    cv.frame_end = frame_end;
    return cv;
  endfunction

  // Advance the shadow smoother by one accepted beat and queue the cells it
  // completes. A cell is done once the cell below-right of it has arrived.
  task automatic smooth_step(input logic [LEVEL_BITS-1:0] lvl, input logic fl);
    logic [wns_pkg::COL_BITS-1:0] c;
    logic [wns_pkg::ROW_BITS-1:0] erow;
    bit                           emit;
    c = in_col;
    // Flush outside the drain and levels during it change nothing.
    if (fl != draining)
      return;

    // Shift the 3x3 window left and load the new column.
    for (int r = 0; r < 3; r++) begin
      win[r*3]     = win[r*3 + 1];
      win[r*3 + 1] = win[r*3 + 2];
    end
    win[2] = older_line[c];
    win[5] = prior_line[c];
    win[8] = draining ? '0 : lvl;
    if (!draining) begin
      older_line[c] = prior_line[c];
      prior_line[c] = lvl;
    end

    if (draining) begin
      erow = out_row;
      emit = 1'b1;
    end else begin
      emit = (in_row >= 1);
      erow = emit ? in_row - wns_pkg::ROW_BITS'(1) : '0;
    end

    if (emit) begin
      // Cell left of the new column.
      if (c >= 1)
        cells_due.push_back(cell_avg(weighted_mean(1, erow > 0, !draining, c > 1, 1'b1),
                                     erow, c - wns_pkg::COL_BITS'(1), 1'b0));
      // Row end: the cell of the new column too; the drain closes the frame.
      if (c >= cfg_last_col)
        cells_due.push_back(cell_avg(weighted_mean(2, erow > 0, !draining, c > 0, 1'b0),
                                     erow, c, draining));
      out_row = erow;
    end

    // Advance the input position; the last row hands over to the drain.
    if (c >= cfg_last_col) begin
      in_col = '0;
      if (draining) begin
        draining = 1'b0;
        in_row   = '0;
      end else if (in_row >= cfg_last_row) begin
        draining = 1'b1;
        out_row  = in_row;
        in_row   = '0;
      end else begin
        in_row = in_row + wns_pkg::ROW_BITS'(1);
      end
    end else begin
      in_col = in_col + wns_pkg::COL_BITS'(1);
    end
  endtask

  int item_gap = 0;

  // Item side: hold each beat until it is taken, idle in random bursts.
  always @(posedge clk) begin
    grid_beat_t beat;
    if (!rst_n) begin
      item_if.valid <= 1'b0;
    end else if (!item_if.valid || item_if.ready) begin
      if (item_gap > 0) begin
        item_if.valid <= 1'b0;
        item_gap      <= item_gap - 1;
      end else if (pending_beats.size() > 0 && !calm && $urandom_range(99) < gap_pct) begin
        item_if.valid <= 1'b0;
        item_gap      <= $urandom_range(9);
      end else if (pending_beats.size() > 0) begin
        beat = pending_beats.pop_front();
        item_if.valid <= 1'b1;
        item_if.level <= beat.level;
        item_if.flush <= beat.flush;
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  // Predict on every accepted item beat.
  always @(posedge clk) begin
    if (rst_n && item_if.valid && item_if.ready)
      smooth_step(item_if.level, item_if.flush);
  end

  // Result side: stall in random bursts, or for a long stretch on request.
  int res_stall = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else if (hold_off) begin
      res_if.ready <= 1'b0;
    end else if (res_stall > 0) begin
      res_if.ready <= 1'b0;
      res_stall    <= res_stall - 1;
    end else if (!calm && $urandom_range(99) < gap_pct) begin
      res_if.ready <= 1'b0;
      res_stall    <= $urandom_range(9);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Long receiver hold-off: let the result queue fill and back-pressure the
  // item side while it keeps offering beats.
  initial begin
    hold_off = 1'b0;
    forever begin
      @(squeeze_ev);
      @(posedge clk);
      hold_off <= 1'b1;
      repeat (400) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  // Compare each result beat with the oldest expected cell.
  always @(posedge clk) begin
    cell_avg_t due;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (cells_due.size() == 0) begin
        $error("unexpected result: row %0d col %0d average %0d",
               res_if.row, res_if.col, res_if.average);
        mismatches++;
      end else begin
        due = cells_due.pop_front();
        if (res_if.average !== due.average) begin
          $error("average: expected %0d, got %0d", due.average, res_if.average);
          mismatches++;
        end
        if (res_if.row !== due.row) begin
          $error("row: expected %0d, got %0d", due.row, res_if.row);
          mismatches++;
        end
        if (res_if.col !== due.col) begin
          $error("col: expected %0d, got %0d", due.col, res_if.col);
          mismatches++;
        end
        if (res_if.frame_end !== due.frame_end) begin
          $error("frame_end: expected %0d, got %0d", due.frame_end, res_if.frame_end);
          mismatches++;
        end
      end
    end
  end

  // Hard limit on the run time.
  initial begin
    #4_000_000;
    $display("tb_weighted_neighbour_smoothing failed");
    $finish;
  end

  function automatic logic [LEVEL_BITS-1:0] pick_level();
    logic [LEVEL_BITS-1:0] lvl;
    case ($urandom_range(9))
      0:       lvl = '0;
      1:       lvl = '1;
      2:       lvl = LEVEL_BITS'($urandom_range(15));
      default: lvl = LEVEL_BITS'($urandom);
    endcase
    return lvl;
  endfunction

  task automatic push_beat(input logic [LEVEL_BITS-1:0] lvl, input logic fl);
    grid_beat_t beat;
    beat.level = lvl;
    beat.flush = fl;
    pending_beats.push_back(beat);
  endtask

  // Wait until every beat is taken and every cell has come out, then give
  // dropped beats time to clear the pipeline.
  task automatic wait_drained();
    while (pending_beats.size() != 0 || item_if.valid || cells_due.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // APB write: setup, then access.
  task automatic reg_write(input wns_pkg::reg_e idx,
                           input logic [wns_pkg::DATA_BITS-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= wns_pkg::ADDR_BITS'(idx) << wns_pkg::REG_SEL_BIT;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Resize the grid; only ever called with the block idle between frames.
  task automatic set_grid(input logic [wns_pkg::ROW_BITS-1:0] rows_last,
                          input logic [wns_pkg::COL_BITS-1:0] cols_last);
    wait_drained();
    reg_write(wns_pkg::REG_LAST_ROW, wns_pkg::DATA_BITS'(rows_last));
    cfg_last_row = rows_last;
    reg_write(wns_pkg::REG_LAST_COL, wns_pkg::DATA_BITS'(cols_last));
    cfg_last_col = cols_last;
  endtask

  // Queue one whole frame plus its drain. Sprinkle beats that the block must
  // drop: a flush among the levels, a level during the drain, a stray flush
  // after the frame.
  task automatic queue_frame(input int noise_pct);
    for (int r = 0; r <= cfg_last_row; r++) begin
      for (int c = 0; c <= cfg_last_col; c++) begin
        if ($urandom_range(99) < noise_pct)
          push_beat(pick_level(), 1'b1);
        push_beat(pick_level(), 1'b0);
        stim_items++;
      end
    end
    for (int c = 0; c <= cfg_last_col; c++) begin
      if ($urandom_range(99) < noise_pct)
        push_beat(pick_level(), 1'b0);
      push_beat(LEVEL_BITS'($urandom), 1'b1);
      stim_items++;
    end
    if ($urandom_range(99) < noise_pct)
      push_beat(pick_level(), 1'b1);
  endtask

  initial begin
    int frames;
    // Drive every input to a known value before reset.
    rst_n         = 1'b0;
    item_if.valid = 1'b0;
    item_if.level = '0;
    item_if.flush = 1'b0;
    res_if.ready  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    cfg_last_row  = wns_pkg::LAST_ROW_RESET;
    cfg_last_col  = wns_pkg::LAST_COL_RESET;
    foreach (older_line[i]) older_line[i] = '0;
    foreach (prior_line[i]) prior_line[i] = '0;
    foreach (win[i]) win[i] = '0;
    in_row   = '0;
    in_col   = '0;
    out_row  = '0;
    draining = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Single cell grid: stray flush first, a level during the drain.
    set_grid(0, 0);
    push_beat('0, 1'b1);
    push_beat('1, 1'b0);
    push_beat('0, 1'b0);
    push_beat('0, 1'b1);

    // Two by two grid with extreme levels: corners only.
    set_grid(1, 1);
    push_beat('0, 1'b0);
    push_beat('1, 1'b0);
    push_beat('1, 1'b0);
    push_beat('0, 1'b0);
    push_beat('0, 1'b1);
    push_beat('0, 1'b1);

    // Single row: plain horizontal averaging.
    set_grid(0, 2);
    push_beat('1, 1'b0);
    push_beat('0, 1'b0);
    push_beat('1, 1'b0);
    push_beat('0, 1'b1);
    push_beat('1, 1'b1);
    push_beat('0, 1'b1);

    // Single column: vertical averaging, one flush drains it.
    set_grid(2, 0);
    push_beat(LEVEL_BITS'(1), 1'b0);
    push_beat('1, 1'b0);
    push_beat('0, 1'b0);
    push_beat('0, 1'b1);

    // Widest grid, one frame, with the receiver holding off a while.
    gap_pct = 10;
    set_grid(1, wns_pkg::COL_BITS'(255));
    queue_frame(2);
    -> squeeze_ev;

    // Random grids, mostly small; quiet channels over the last stretch.
    while (stim_items < 1700) begin
      calm = (stim_items >= 1400);
      case ($urandom_range(3))
        0:       gap_pct = 0;
        1:       gap_pct = 5;
        2:       gap_pct = 20;
        default: gap_pct = 50;
      endcase
      if ($urandom_range(7) == 0)
        set_grid(wns_pkg::ROW_BITS'($urandom_range(0, 1)),
                 wns_pkg::COL_BITS'($urandom_range(16, 63)));
      else
        set_grid(wns_pkg::ROW_BITS'($urandom_range(0, 7)),
                 wns_pkg::COL_BITS'($urandom_range(0, 15)));
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        if (stim_items < 1700)
          queue_frame(4);
      end
      if (stim_items < 1200 && $urandom_range(9) == 0)
        -> squeeze_ev;
    end

    wait_drained();
    if (mismatches == 0)
      $display("tb_weighted_neighbour_smoothing passed");
    else
      $display("tb_weighted_neighbour_smoothing failed");
    $finish;
  end

endmodule

FILE: filelist.f
src/wns_pkg.sv
src/wns_if.sv
src/wns_cfg.sv
src/wns_line_buf.sv
src/wns_smooth.sv
src/wns_out_fifo.sv
src/weighted_neighbour_smoothing.sv
tb/sv/tb_weighted_neighbour_smoothing.sv
